// ===== rtl/sha_pkg.sv =====
`default_nettype none
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenFieldPos = 56;
  localparam int unsigned TotalBits = 61;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  // controller to datapath
  typedef struct packed {
    logic       wr_en;       // write wr_byte at wr_addr
    logic [5:0] wr_addr;
    logic [7:0] wr_byte;
    logic       comp_start;  // begin a 64-round compression
    logic       h_reset;     // load the initial hash value
  } sha_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic comp_busy;
    logic comp_done;
  } sha_sts_t;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sha256_stream_hasher.sv =====
// sha-256 over a byte stream
// input channel: in_valid_i / in_stall_o with an in_data_i request holding
//   data_byte, has_byte and is_last; an accepted byte is buffered, is_last
//   closes the message (the byte of the same request belongs to it)
// output channel: out_valid_o / out_stall_i with out_data_o holding one
//   digest word, its index and a last-word flag; eight requests per message
// byte intake: every 64th byte starts a compression, one round per cycle
//   in a single shared round unit, and input stays stalled until that
//   compression is done
// end of message: padding writes one byte per cycle up to the block end
//   (plus a second block when more than 55 bytes are pending), each
//   block followed by a compression, then eight digest words at one per
//   cycle while the receiver does not stall
// reset: hash words load the initial value, byte and fill counts clear,
//   no output is pending
// a stalled receiver holds the output register; the digest sequencer
//   waits and the input stays stalled until the last word is loaded into
//   the output register
`default_nettype none
module sha256_stream_hasher
  import sha_pkg::*;
#(
  parameter int unsigned TotalW = TotalBits
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire sha_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output sha_out_t      out_data_o
);

  sha_cmd_t    cmd;
  sha_sts_t    sts;
  logic [2:0]  rd_idx;
  logic [31:0] rd_word;

  // sequencing: byte intake, padding, length field and digest readout
  sha_ctrl #(.TotalW(TotalW)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cmd_o(cmd), .sts_i(sts), .rd_idx_o(rd_idx), .rd_word_i(rd_word)
  );

  // block buffer, message schedule, round unit and hash words
  sha_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .rd_idx_i(rd_idx), .rd_word_o(rd_word)
  );

endmodule
`default_nettype wire

// ===== rtl/sha_datapath.sv =====
`default_nettype none
module sha_datapath
  import sha_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire sha_cmd_t    cmd_i,
  output sha_sts_t         sts_o,
  input  wire logic [2:0]  rd_idx_i,
  output logic [31:0]      rd_word_o
);

  // block buffer as 16 message words; only written entries are ever read
  logic [31:0] w_q [16];
  logic [31:0] h_q [8];
  logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q;
  logic [6:0]  rnd_q;
  logic        busy_q, done_q;

  logic [31:0] wt, s0, s1, wnew, big0, big1, ch, maj, t1, t2;

  assign wt   = w_q[0];
  assign s0   = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1   = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
  assign wnew = w_q[0] + s0 + w_q[9] + s1;
  assign big1 = rotr(e_q, 6) ^ rotr(e_q, 11) ^ rotr(e_q, 25);
  assign ch   = (e_q & f_q) ^ (~e_q & g_q);
  assign t1   = hh_q + big1 + ch + RoundK[rnd_q[5:0]] + wt;
  assign big0 = rotr(a_q, 2) ^ rotr(a_q, 13) ^ rotr(a_q, 22);
  assign maj  = (a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q);
  assign t2   = big0 + maj;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
    end else begin
      done_q <= 1'b0;
      if (cmd_i.h_reset) begin
        for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
      end
      if (cmd_i.comp_start) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        if (rnd_q == 7'd64) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
          h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
          h_q[4] <= h_q[4] + e_q; h_q[5] <= h_q[5] + f_q;
          h_q[6] <= h_q[6] + g_q; h_q[7] <= h_q[7] + hh_q;
        end else begin
          rnd_q <= rnd_q + 7'd1;
        end
      end
    end
  end

  // working variables and the rolling message schedule
  always_ff @(posedge clk_i) begin
    if (busy_q && rnd_q != 7'd64) begin
      hh_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
      d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
    end else begin
      if (cmd_i.comp_start) begin
        a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
        e_q <= h_q[4]; f_q <= h_q[5]; g_q <= h_q[6]; hh_q <= h_q[7];
      end
      // the byte that completes a block arrives together with the start
      if (cmd_i.wr_en) begin
        case (cmd_i.wr_addr[1:0])
          2'd0: w_q[cmd_i.wr_addr[5:2]][31:24] <= cmd_i.wr_byte;
          2'd1: w_q[cmd_i.wr_addr[5:2]][23:16] <= cmd_i.wr_byte;
          2'd2: w_q[cmd_i.wr_addr[5:2]][15:8]  <= cmd_i.wr_byte;
          default: w_q[cmd_i.wr_addr[5:2]][7:0] <= cmd_i.wr_byte;
        endcase
      end
    end
  end

  assign sts_o.comp_busy = busy_q;
  assign sts_o.comp_done = done_q;
  assign rd_word_o = h_q[rd_idx_i];

  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !cmd_i.wr_en) else $error("buffer written during compression");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("done without compression");
  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rnd_q <= 7'd64) else $error("round count out of range");

endmodule
`default_nettype wire

// ===== rtl/sha_ctrl.sv =====
`default_nettype none
module sha_ctrl
  import sha_pkg::*;
#(
  parameter int unsigned TotalW = TotalBits
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire sha_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output sha_out_t         out_data_o,
  output sha_cmd_t         cmd_o,
  input  wire sha_sts_t    sts_i,
  output logic [2:0]       rd_idx_o,
  input  wire logic [31:0] rd_word_i
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_COMP  = 7'b0000010,
    ST_PAD   = 7'b0000100,
    ST_PCOMP = 7'b0001000,
    ST_LEN   = 7'b0010000,
    ST_LCOMP = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_e;

  state_e      state_q, state_d;
  logic [6:0]  fill_q, fill_d;
  logic [TotalW-1:0] total_q, total_d;
  logic        last_q, last_d;
  logic [2:0]  idx_q, idx_d;
  logic        ov_q, ov_d;
  sha_out_t    od_q, od_d;
  logic        acc;
  logic [63:0] bit_len;

  assign in_stall_o = (state_q != ST_IDLE);
  assign acc = in_valid_i && !in_stall_o;
  assign bit_len = 64'({total_q, 3'b000});
  assign rd_idx_o = idx_q;

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    total_d = total_q;
    last_d  = last_q;
    idx_d   = idx_q;
    ov_d    = ov_q;
    od_d    = od_q;
    cmd_o   = '0;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          last_d = in_data_i.is_last;
          if (in_data_i.has_byte) begin
            cmd_o.wr_en   = 1'b1;
            cmd_o.wr_addr = fill_q[5:0];
            cmd_o.wr_byte = in_data_i.data_byte;
            fill_d  = fill_q + 7'd1;
            total_d = total_q + 1'b1;
            if (fill_q == 7'd63) begin
              cmd_o.comp_start = 1'b1;
              fill_d  = '0;
              state_d = ST_COMP;
            end else if (in_data_i.is_last) begin
              state_d = ST_PAD;
            end
          end else if (in_data_i.is_last) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_COMP: begin
        if (sts_i.comp_done) state_d = last_q ? ST_PAD : ST_IDLE;
      end
      ST_PAD: begin
        // 0x80 marker, then zeros up to the length field or block end
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = fill_q[5:0];
        cmd_o.wr_byte = (fill_q[6] == 1'b0 && last_q) ? 8'h80 : 8'h00;
        last_d = 1'b0;
        fill_d = fill_q + 7'd1;
        if (fill_q == 7'd63) begin
          cmd_o.comp_start = 1'b1;
          fill_d  = '0;
          state_d = ST_PCOMP;
        end else if (fill_q == 7'd55) begin
          fill_d  = 7'd56;
          state_d = ST_LEN;
        end
      end
      ST_PCOMP: begin
        if (sts_i.comp_done) state_d = ST_PAD;
      end
      ST_LEN: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = fill_q[5:0];
        cmd_o.wr_byte = bit_len[8*(7 - (fill_q[2:0])) +: 8];
        fill_d = fill_q + 7'd1;
        if (fill_q == 7'd63) begin
          cmd_o.comp_start = 1'b1;
          fill_d  = '0;
          idx_d   = '0;
          state_d = ST_LCOMP;
        end
      end
      ST_LCOMP: begin
        if (sts_i.comp_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1;
          od_d.digest_word = rd_word_i;
          od_d.word_index  = idx_q;
          od_d.last_word   = (idx_q == 3'd7);
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            cmd_o.h_reset = 1'b1;
            total_d = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      total_q <= '0;
      last_q  <= 1'b0;
      idx_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      total_q <= total_d;
      last_q  <= last_d;
      idx_q   <= idx_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) od_q <= od_d;

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> fill_q < 7'd64) else $error("fill count out of range");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.comp_start |=> sts_i.comp_busy) else $error("compression did not start");
  a_emit_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> !sts_i.comp_busy) else $error("emit during compression");

endmodule
`default_nettype wire
